// File: rtl/rafm_pkg.sv
// ----------------------------------------------------------------------------
// rafm_pkg
// Shared types and constants for the rotated array first-match search block.
// ----------------------------------------------------------------------------
package rafm_pkg;

	localparam int SLOT_BITS  = 10;
	localparam int LEN_BITS   = 11;
	localparam int VALUE_BITS = 32;
	localparam int POS_BITS   = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                         op;
		logic [SLOT_BITS-1:0]         slot;
		logic signed [VALUE_BITS-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] position;
		logic [POS_BITS-1:0] rotation;
	} result_word_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_R_ISSUE = 7'b0000010,
		ST_R_CMP   = 7'b0000100,
		ST_L_ISSUE = 7'b0001000,
		ST_L_CMP   = 7'b0010000,
		ST_F_ISSUE = 7'b0100000,
		ST_F_CMP   = 7'b1000000
	} state_t;

endpackage

// File: rtl/rafm_mem.sv
// ----------------------------------------------------------------------------
// rafm_mem
// Element store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rafm_mem import rafm_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                                        clk,
	input  mem_ctl_t                                    mem_ctl,
	input  logic [$clog2(DEPTH)-1:0]                    wr_addr,
	input  logic [((WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS)-1:0] wr_data,
	input  logic [$clog2(DEPTH)-1:0]                    rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]                    rd_addr_b,
	output logic signed [((WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS)-1:0] rd_data_a,
	output logic signed [((WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS)-1:0] rd_data_b
);

	localparam int EW = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;

	logic [EW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_ctl.rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: rtl/rafm_ctrl.sv
// ----------------------------------------------------------------------------
// rafm_ctrl
// Search sequencer: rotation-point search, then lower bound over ranks; also drives store writes.
// ----------------------------------------------------------------------------
module rafm_ctrl import rafm_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  cmd_word_t                                   cmd,
	input  logic [$clog2(DEPTH):0]                      live_n,
	input  logic signed [((WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS)-1:0] rd_data_a,
	input  logic signed [((WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS)-1:0] rd_data_b,
	output logic                                        busy,
	output logic                                        done,
	output result_word_t                                result,
	output mem_ctl_t                                    mem_ctl,
	output logic [$clog2(DEPTH)-1:0]                    wr_addr,
	output logic [((WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS)-1:0] wr_data,
	output logic [$clog2(DEPTH)-1:0]                    rd_addr_a,
	output logic [$clog2(DEPTH)-1:0]                    rd_addr_b
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int EW = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
	localparam int SW = (CW > SLOT_BITS) ? CW : SLOT_BITS;

	state_t                       state_q;
	logic [CW-1:0]                lo_q, hi_q, mid_q, n_q, p_q;
	logic [AW-1:0]                idx_q;
	logic signed [VALUE_BITS-1:0] key_q;
	logic                         done_q;
	result_word_t                 result_q;

	logic [CW:0]                  sum_w, rsum_w, rwrap_w;
	logic [CW-1:0]                mid_w, rank_w;
	logic [AW-1:0]                idx_w;
	logic signed [VALUE_BITS-1:0] elem_w;
	logic                         accept_w, slot_ok_w;
	logic                         wr_en_w, rd_en_w;

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign result   = result_q;
	assign accept_w = start && !busy;

	assign slot_ok_w       = SW'(cmd.slot) < SW'(DEPTH);
	assign wr_en_w         = accept_w && (cmd.op == OP_WRITE) && slot_ok_w;
	assign wr_addr         = AW'(cmd.slot);
	assign wr_data         = cmd.value[EW-1:0];

	assign sum_w   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = sum_w[CW:1];
	assign rank_w  = (state_q == ST_L_ISSUE) ? mid_w : lo_q;
	assign rsum_w  = {1'b0, p_q} + {1'b0, rank_w};
	assign rwrap_w = (rsum_w >= {1'b0, n_q}) ? (rsum_w - {1'b0, n_q}) : rsum_w;
	assign idx_w   = rwrap_w[AW-1:0];

	assign rd_en_w       = (state_q == ST_R_ISSUE) || (state_q == ST_L_ISSUE) ||
	                       (state_q == ST_F_ISSUE);
	assign mem_ctl       = '{wr_en: wr_en_w, rd_en: rd_en_w};
	assign rd_addr_a     = (state_q == ST_R_ISSUE) ? mid_w[AW-1:0] : idx_w;
	assign rd_addr_b     = hi_q[AW-1:0];

	assign elem_w = VALUE_BITS'(rd_data_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept_w && (cmd.op == OP_QUERY)) begin
						state_q <= ST_R_ISSUE;
					end
				end
				ST_R_ISSUE: begin
					state_q <= (lo_q < hi_q) ? ST_R_CMP : ST_L_ISSUE;
				end
				ST_R_CMP: begin
					state_q <= ST_R_ISSUE;
				end
				ST_L_ISSUE: begin
					state_q <= (lo_q < hi_q) ? ST_L_CMP : ST_F_ISSUE;
				end
				ST_L_CMP: begin
					state_q <= ST_L_ISSUE;
				end
				ST_F_ISSUE: begin
					if (lo_q < n_q) begin
						state_q <= ST_F_CMP;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_F_CMP: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= cmd.value;
				n_q   <= live_n;
				lo_q  <= '0;
				hi_q  <= live_n - CW'(1);
			end
			ST_R_ISSUE: begin
				if (lo_q < hi_q) begin
					mid_q <= mid_w;
				end else begin
					p_q  <= lo_q;
					lo_q <= '0;
					hi_q <= n_q;
				end
			end
			ST_R_CMP: begin
				if (rd_data_a > rd_data_b) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_L_ISSUE: begin
				mid_q <= mid_w;
			end
			ST_L_CMP: begin
				if (elem_w < key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_F_ISSUE: begin
				idx_q             <= idx_w;
				result_q.found    <= 1'b0;
				result_q.position <= '0;
				result_q.rotation <= POS_BITS'(p_q);
			end
			ST_F_CMP: begin
				result_q.found    <= (elem_w == key_q);
				result_q.position <= (elem_w == key_q) ? POS_BITS'(idx_q) : '0;
				result_q.rotation <= POS_BITS'(p_q);
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

// File: rtl/rotated_array_first_match_top.sv
// ----------------------------------------------------------------------------
// rotated_array_first_match_top
// Search for the first occurrence of a key in a rotated sorted array.
// ----------------------------------------------------------------------------
// Command channel: a word on cmd is taken at a clock edge with start high and
// busy low. A write word (op = 0) stores value at slot and gives
// no result; busy stays low, so writes may follow back to back. A query word
// (op = 1) raises busy until its result is out.
// Result channel: done is high for exactly one cycle with the result word on
// result; there is no backpressure, the receiver must take it then. busy is
// low again in that same cycle, so the next command can be taken with it.
// Configuration: length_we writes length_wdata into the length register at
// the clock edge; do so only while busy is low.
// Query steps, with n the live length (0 acts as 1, saturated to DEPTH): a
// binary search for the rotation point over n elements, then a lower-bound
// search for the key over ranks, then, if the bound lies below n, a read at
// that rank to check for a match. Each probe reads the store, then compares.
// Reset: arst_n clears the sequencer and sets length to 1; the element store
// is not cleared and must be written before it is searched.
// ----------------------------------------------------------------------------
module rotated_array_first_match_top import rafm_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmd_word_t           cmd,
	output logic                done,
	output result_word_t        result,
	input  logic                length_we,
	input  logic [LEN_BITS-1:0] length_wdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int EW = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
	localparam int LW = (CW > LEN_BITS) ? CW : LEN_BITS;

	logic [LEN_BITS-1:0]  length_q;
	logic [LW-1:0]        len_ext;
	logic [CW-1:0]        live_n;
	mem_ctl_t             mem_ctl;
	logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
	logic [EW-1:0]        wr_data;
	logic signed [EW-1:0] rd_data_a, rd_data_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_BITS'(1);
		end else if (length_we) begin
			length_q <= length_wdata;
		end
	end

	assign len_ext = LW'(length_q);

	always_comb begin
		if (length_q == '0) begin
			live_n = CW'(1);
		end else if (len_ext > LW'(DEPTH)) begin
			live_n = CW'(DEPTH);
		end else begin
			live_n = CW'(len_ext);
		end
	end

	rafm_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.live_n    (live_n),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	rafm_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk       (clk),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

endmodule

// File: rtl/rafm_check.sv
// ----------------------------------------------------------------------------
// rafm_check
// Port-level checks on command, result and busy behavior of the search block.
// ----------------------------------------------------------------------------
module rafm_check import rafm_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input cmd_word_t    cmd,
	input logic         done,
	input result_word_t result
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high with a result out");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_QUERY) |=> (busy && !done))
		else $error("query taken without going busy");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_WRITE) |=> (!busy && !done))
		else $error("write word caused busy or a result");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.position == '0))
		else $error("position nonzero on a miss");

endmodule

bind rotated_array_first_match_top rafm_check u_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
